### rtl/bfe_pkg.sv
// ----------------------------------------------------------------------------
// bfe_pkg
// Types, constants and the SipHash round shared by the Bloom filter engine.
// ----------------------------------------------------------------------------
package bfe_pkg;

	localparam logic [63:0] SIP_INIT_A = 64'h736f6d6570736575;
	localparam logic [63:0] SIP_INIT_B = 64'h646f72616e646f6d;
	localparam logic [63:0] SIP_INIT_C = 64'h6c7967656e657261;
	localparam logic [63:0] SIP_INIT_D = 64'h7465646279746573;
	localparam logic [63:0] SIP_FIN_XOR = 64'h00000000000000ff;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEED_0    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SEED_1    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SEED_2    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WORDS     = 3'd5;

	localparam logic CMD_INSERT = 1'b1;

	localparam int WORDS_W   = 11;
	localparam int DIV_STEPS = 58;
	localparam int NPROBE    = 3;

	typedef struct packed {
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] c;
		logic [63:0] d;
	} lanes_t;

	typedef enum logic [2:0] {
		LN_HOLD,
		LN_LOAD_IN,
		LN_LOAD_TAIL,
		LN_ROUND,
		LN_ROUND_XA,
		LN_FIN,
		LN_RELOAD
	} lane_op_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RND1,
		ST_RND2,
		ST_TAIL,
		ST_FIN,
		ST_FRND,
		ST_HASH,
		ST_DIV,
		ST_PRD,
		ST_PCHK,
		ST_OUT
	} state_t;

	typedef struct packed {
		lane_op_t    lane_op;
		logic        accept;
		logic        clr_wr;
		logic        hash_ld;
		logic        div_step;
		logic        rd_en;
		logic        probe_chk;
		logic [1:0]  probe;
		logic        out_ld;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic last;
		logic full;
		logic out_free;
	} dp_status_t;

	function automatic logic [63:0] rotl(logic [63:0] x, int n);
		return (x << n) | (x >> (64 - n));
	endfunction

	function automatic lanes_t sip_round(lanes_t v);
		lanes_t r;
		r = v;
		r.a = r.a + r.b; r.b = rotl(r.b, 13); r.b = r.b ^ r.a; r.a = rotl(r.a, 32);
		r.c = r.c + r.d; r.d = rotl(r.d, 16); r.d = r.d ^ r.c;
		r.a = r.a + r.d; r.d = rotl(r.d, 21); r.d = r.d ^ r.a;
		r.c = r.c + r.b; r.b = rotl(r.b, 17); r.b = r.b ^ r.c; r.c = rotl(r.c, 32);
		return r;
	endfunction

endpackage

### rtl/bfe_if.sv
// ----------------------------------------------------------------------------
// bfe_if
// Valid/ready channels of the Bloom filter engine: key words, results, config.
// ----------------------------------------------------------------------------
interface bfe_in_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [63:0] key_word;
	logic [3:0]  word_bytes;
	logic        last_word;

	modport source(output valid, command, key_word, word_bytes, last_word, input ready);
	modport sink(input valid, command, key_word, word_bytes, last_word, output ready);
endinterface

interface bfe_out_if;
	logic        valid;
	logic        ready;
	logic        maybe_present;
	logic [63:0] key_hash;

	modport source(output valid, maybe_present, key_hash, input ready);
	modport sink(input valid, maybe_present, key_hash, output ready);
endinterface

interface bfe_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [63:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### rtl/bfe_ram.sv
// ----------------------------------------------------------------------------
// bfe_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module bfe_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

### rtl/bfe_ctrl.sv
// ----------------------------------------------------------------------------
// bfe_ctrl
// Sequencer: clearing pass, absorb rounds, finalisation, division and probes.
// ----------------------------------------------------------------------------
module bfe_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  bfe_pkg::dp_status_t   st,
	output bfe_pkg::ctrl_cmd_t    cmd
);
	import bfe_pkg::*;

	state_t     state_q, state_d;
	logic [5:0] cnt_q;
	logic [1:0] probe_q;
	logic       tail_done_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (st.clr_done) state_d = ST_IDLE;
			ST_IDLE:  if (in_valid) state_d = ST_RND1;
			ST_TAIL:  state_d = ST_RND1;
			ST_RND1:  state_d = ST_RND2;
			ST_RND2: begin
				if (!st.last) state_d = ST_IDLE;
				else if (st.full && !tail_done_q) state_d = ST_TAIL;
				else state_d = ST_FIN;
			end
			ST_FIN:   state_d = ST_FRND;
			ST_FRND:  if (cnt_q == 6'd3) state_d = ST_HASH;
			ST_HASH:  state_d = ST_DIV;
			ST_DIV:   if (cnt_q == 6'(DIV_STEPS - 1)) state_d = ST_PRD;
			ST_PRD:   state_d = ST_PCHK;
			ST_PCHK:  state_d = (probe_q == 2'(NPROBE - 1)) ? ST_OUT : ST_PRD;
			ST_OUT:   if (st.out_free) state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd       = '0;
		cmd.probe = probe_q;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_CLEAR: cmd.clr_wr = 1'b1;
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept  = 1'b1;
					cmd.lane_op = LN_LOAD_IN;
				end
			end
			ST_TAIL:  cmd.lane_op = LN_LOAD_TAIL;
			ST_RND1:  cmd.lane_op = LN_ROUND;
			ST_RND2:  cmd.lane_op = LN_ROUND_XA;
			ST_FIN:   cmd.lane_op = LN_FIN;
			ST_FRND:  cmd.lane_op = LN_ROUND;
			ST_HASH:  cmd.hash_ld = 1'b1;
			ST_DIV:   cmd.div_step = 1'b1;
			ST_PRD:   cmd.rd_en = 1'b1;
			ST_PCHK:  cmd.probe_chk = 1'b1;
			ST_OUT: begin
				if (st.out_free) begin
					cmd.out_ld  = 1'b1;
					cmd.lane_op = LN_RELOAD;
				end
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			probe_q     <= '0;
			tail_done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FIN || state_q == ST_HASH) begin
				cnt_q <= '0;
			end else if (state_q == ST_FRND || state_q == ST_DIV) begin
				cnt_q <= cnt_q + 6'd1;
			end
			if (state_q == ST_HASH) begin
				probe_q <= '0;
			end else if (state_q == ST_PCHK) begin
				probe_q <= probe_q + 2'd1;
			end
			if (state_q == ST_IDLE) begin
				tail_done_q <= 1'b0;
			end else if (state_q == ST_TAIL) begin
				tail_done_q <= 1'b1;
			end
		end
	end
endmodule

### rtl/bfe_dp.sv
// ----------------------------------------------------------------------------
// bfe_dp
// Datapath: configuration registers, SipHash lanes, remainder units, filter.
// ----------------------------------------------------------------------------
module bfe_dp #(
	parameter int FILTER_DEPTH = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bfe_pkg::ctrl_cmd_t   cmd,
	output bfe_pkg::dp_status_t  st,
	input  logic                 cfg_valid,
	input  logic [2:0]           cfg_index,
	input  logic [63:0]          cfg_data,
	input  logic                 command,
	input  logic [63:0]          key_word,
	input  logic [3:0]           word_bytes,
	input  logic                 last_word,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic                 maybe_present,
	output logic [63:0]          key_hash
);
	import bfe_pkg::*;

	localparam int AW = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;

	logic [63:0]        key_lo_q, key_hi_q, key_lo_n, key_hi_n;
	logic [63:0]        seed_q [NPROBE];
	logic [WORDS_W-1:0] words_q, w_eff;
	lanes_t             lanes_q, rnd;
	logic [63:0]        m_q, tail_q, tail_c, msg_in, masked;
	logic [7:0]         len_q, len_new;
	logic [3:0]         nb_c;
	logic               full_c, last_q, full_q, cmd_q;
	logic               key_wr;
	logic [DIV_STEPS-1:0] divd_q [NPROBE];
	logic [WORDS_W-1:0] rem_q [NPROBE];
	logic [5:0]         bitsel_q [NPROBE];
	logic [63:0]        hash_c, hash_q;
	logic               all_set_q, out_valid_q;
	logic [AW-1:0]      clr_cnt_q, ram_waddr, ram_raddr;
	logic               ram_we;
	logic [63:0]        ram_wdata, ram_rdata, probe_mask;

	// Effective filter size in words: zero acts as one, clamp to the store.
	always_comb begin
		if (words_q == '0) w_eff = WORDS_W'(1);
		else if (32'(words_q) > 32'(FILTER_DEPTH)) w_eff = WORDS_W'(FILTER_DEPTH);
		else w_eff = words_q;
	end

	assign key_wr   = cfg_valid && (cfg_index == REG_KEY_LOW || cfg_index == REG_KEY_HIGH);
	assign key_lo_n = (cfg_valid && cfg_index == REG_KEY_LOW) ? cfg_data : key_lo_q;
	assign key_hi_n = (cfg_valid && cfg_index == REG_KEY_HIGH) ? cfg_data : key_hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_lo_q <= '0;
			key_hi_q <= '0;
			for (int i = 0; i < NPROBE; i++) seed_q[i] <= '0;
			words_q  <= 11'd1024;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_KEY_LOW:  key_lo_q  <= cfg_data;
				REG_KEY_HIGH: key_hi_q  <= cfg_data;
				REG_SEED_0:   seed_q[0] <= cfg_data;
				REG_SEED_1:   seed_q[1] <= cfg_data;
				REG_SEED_2:   seed_q[2] <= cfg_data;
				REG_WORDS:    words_q   <= cfg_data[WORDS_W-1:0];
				default:      words_q   <= words_q;
			endcase
		end
	end

	// Incoming word: byte count, running length and the tail block.
	always_comb begin
		nb_c    = (word_bytes > 4'd8) ? 4'd8 : word_bytes;
		full_c  = (nb_c == 4'd8);
		len_new = len_q + (last_word ? {4'b0, nb_c} : 8'd8);
		for (int i = 0; i < 8; i++) begin
			masked[8*i +: 8] = (4'(i) < nb_c && !full_c) ? key_word[8*i +: 8] : 8'h00;
		end
		tail_c = {len_new, masked[55:0]};
		msg_in = (last_word && !full_c) ? tail_c : key_word;
	end

	assign rnd = sip_round(lanes_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lanes_q <= '{a: SIP_INIT_A, b: SIP_INIT_B, c: SIP_INIT_C, d: SIP_INIT_D};
			len_q   <= '0;
		end else if (key_wr || cmd.lane_op == LN_RELOAD) begin
			lanes_q.a <= key_lo_n ^ SIP_INIT_A;
			lanes_q.b <= key_hi_n ^ SIP_INIT_B;
			lanes_q.c <= key_lo_n ^ SIP_INIT_C;
			lanes_q.d <= key_hi_n ^ SIP_INIT_D;
			len_q     <= '0;
		end else begin
			unique case (cmd.lane_op)
				LN_LOAD_IN: begin
					lanes_q.d <= lanes_q.d ^ msg_in;
					len_q     <= len_new;
				end
				LN_LOAD_TAIL: lanes_q.d <= lanes_q.d ^ tail_q;
				LN_ROUND:     lanes_q <= rnd;
				LN_ROUND_XA: begin
					lanes_q <= '{a: rnd.a ^ m_q, b: rnd.b, c: rnd.c, d: rnd.d};
				end
				LN_FIN:  lanes_q.c <= lanes_q.c ^ SIP_FIN_XOR;
				default: lanes_q <= lanes_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			m_q    <= msg_in;
			tail_q <= tail_c;
			last_q <= last_word;
			full_q <= full_c;
			cmd_q  <= command;
		end else if (cmd.lane_op == LN_LOAD_TAIL) begin
			m_q <= tail_q;
		end
	end

	assign hash_c = lanes_q.a ^ lanes_q.b ^ lanes_q.c ^ lanes_q.d;

	// Three restoring remainder units, one dividend bit per cycle each.
	always_ff @(posedge clk) begin
		if (cmd.hash_ld) begin
			hash_q <= hash_c;
			for (int i = 0; i < NPROBE; i++) begin
				divd_q[i]   <= hash_c[63:6] ^ seed_q[i][63:6];
				bitsel_q[i] <= hash_c[5:0] ^ seed_q[i][5:0];
				rem_q[i]    <= '0;
			end
		end else if (cmd.div_step) begin
			for (int i = 0; i < NPROBE; i++) begin
				logic [WORDS_W:0] t;
				t = {rem_q[i], divd_q[i][DIV_STEPS-1]};
				if (t >= {1'b0, w_eff}) t = t - {1'b0, w_eff};
				rem_q[i]  <= t[WORDS_W-1:0];
				divd_q[i] <= {divd_q[i][DIV_STEPS-2:0], 1'b0};
			end
		end
	end

	// Filter store: clearing pass after reset, then probes that read and, for inserts, write back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_wr && clr_cnt_q != AW'(FILTER_DEPTH - 1)) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
		end
	end

	assign probe_mask = 64'd1 << bitsel_q[cmd.probe];
	assign ram_raddr  = AW'(rem_q[cmd.probe]);
	assign ram_we     = cmd.clr_wr || (cmd.probe_chk && cmd_q == CMD_INSERT);
	assign ram_waddr  = cmd.clr_wr ? clr_cnt_q : ram_raddr;
	assign ram_wdata  = cmd.clr_wr ? 64'd0 : (ram_rdata | probe_mask);

	bfe_ram #(
		.WIDTH(64),
		.DEPTH(FILTER_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd_en),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.hash_ld) begin
			all_set_q <= 1'b1;
		end else if (cmd.probe_chk && (ram_rdata & probe_mask) == 64'd0) begin
			all_set_q <= 1'b0;
		end
		if (cmd.out_ld) begin
			maybe_present <= (cmd_q == CMD_INSERT) || all_set_q;
			key_hash      <= hash_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign st.clr_done = (clr_cnt_q == AW'(FILTER_DEPTH - 1));
	assign st.last     = last_q;
	assign st.full     = full_q;
	assign st.out_free = !out_valid_q || out_ready;
endmodule

### rtl/bloom_filter_engine.sv
// A key word that is not last is absorbed in states ST_RND1 and ST_RND2; the next word is taken back in idle.
// A last word goes on to finalisation, the bit-serial remainder over 58 dividend bits and three store
// probes before its result; a last word holding all eight bytes first absorbs an extra tail block.
// Reset is asynchronous; a clearing pass then zeroes every word of the filter store,
// during which no key word is taken, while configuration writes are accepted throughout.
// ----------------------------------------------------------------------------
// bloom_filter_engine
// Keyed Bloom filter over streamed keys, hashed with SipHash-2-4.
// ----------------------------------------------------------------------------
module bloom_filter_engine #(
	parameter int FILTER_DEPTH = 1024
) (
	input logic       clk,
	input logic       arst_n,
	bfe_in_if.sink    in_item,
	bfe_out_if.source out_item,
	bfe_cfg_if.sink   cfg
);
	import bfe_pkg::*;

	// The controller steps the sequence; the datapath holds every register
	// that carries data, including the result register, which lets the
	// sequencer return to idle while a result still waits to be taken.
	ctrl_cmd_t  cmd;
	dp_status_t st;

	// Configuration writes are always taken; the user must issue them only while idle, as the block does not enforce it.
	assign cfg.ready = 1'b1;

	bfe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_item.valid),
		.in_ready (in_item.ready),
		.st       (st),
		.cmd      (cmd)
	);

	bfe_dp #(
		.FILTER_DEPTH(FILTER_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.cfg_valid     (cfg.valid),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.command       (in_item.command),
		.key_word      (in_item.key_word),
		.word_bytes    (in_item.word_bytes),
		.last_word     (in_item.last_word),
		.out_ready     (out_item.ready),
		.out_valid     (out_item.valid),
		.maybe_present (out_item.maybe_present),
		.key_hash      (out_item.key_hash)
	);
endmodule
